@@ src/cbiq_pkg.sv @@
// ----------------------------------------------------------------------------
// cbiq_pkg: shared types and constants of the cascaded biquad filter
// Field widths, fixed-point formats, product sequence codes and the
// saturation helpers used by the interfaces and the filter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cbiq_pkg;

   // request and response field widths
   localparam int FUNC_W    = 1;
   localparam int ADDR_W    = 7;
   localparam int COEF_W    = 32;
   localparam int SAMPLE_W  = 16;

   // datapath widths: Q8.23 values, 64-bit products, guarded accumulator
   localparam int VALUE_W   = 32;
   localparam int PROD_W    = 64;
   localparam int ACC_W     = 40;
   localparam int FRAC_SH   = 28;

   localparam int WORDS_PER_SECTION = 7;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_FILTER = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_COEF   = 1'b1;

   // one code per coefficient product of a section, then the total gain
   typedef enum logic [2:0] {
      OP_A1W1  = 3'd0,
      OP_A2W2  = 3'd1,
      OP_A0T   = 3'd2,
      OP_B0W   = 3'd3,
      OP_B1W1  = 3'd4,
      OP_B2W2  = 3'd5,
      OP_GAIN  = 3'd6,
      OP_TOTAL = 3'd7
   } op_type;

   // coefficient word offset inside a section for each product
   function automatic logic [2:0] coef_offset(input op_type op);
      logic [2:0] off;
      case (op)
         OP_A1W1:  off = 3'd1;
         OP_A2W2:  off = 3'd2;
         OP_A0T:   off = 3'd0;
         OP_B0W:   off = 3'd3;
         OP_B1W1:  off = 3'd4;
         OP_B2W2:  off = 3'd5;
         OP_GAIN:  off = 3'd6;
         default:  off = 3'd0;
      endcase
      return off;
   endfunction

   // accumulator value does not fit 32 bits
   function automatic logic sat_ovf(input logic [ACC_W-1:0] v);
      return !((&v[ACC_W-1:VALUE_W-1]) || !(|v[ACC_W-1:VALUE_W-1]));
   endfunction

   // clip accumulator value to 32-bit signed
   function automatic logic [VALUE_W-1:0] sat32(input logic [ACC_W-1:0] v);
      logic [VALUE_W-1:0] r;
      if (sat_ovf(v)) begin
         r = v[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/cbiq_if.sv @@
// ----------------------------------------------------------------------------
// cbiq_if: request and response channels of the cascaded biquad filter
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbiq_req_if;
   import cbiq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic [ADDR_W-1:0]          coef_addr;
   logic signed [COEF_W-1:0]   coef_value;
   logic signed [SAMPLE_W-1:0] sample_in;

   modport source (output valid, func, coef_addr, coef_value, sample_in, input ready);
   modport sink   (input valid, func, coef_addr, coef_value, sample_in, output ready);
endinterface

interface cbiq_rsp_if;
   import cbiq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       saturated;

   modport source (output valid, sample_out, saturated, input ready);
   modport sink   (input valid, sample_out, saturated, output ready);
endinterface

`default_nettype wire

@@ src/cascaded_biquad_iir_filter_unit.sv @@
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter_unit: fixed-point cascade of biquad sections
// Direct-form-II second-order sections in series, one shared multiplier
// and accumulator stepping through every coefficient product.
// ----------------------------------------------------------------------------
// usage
//   req_bus carries two kinds of request. func = coefficient write stores
//   coef_value at coef_addr (section*7 + a0,a1,a2,b0,b1,b2,gain, then the
//   total gain); addresses past the table are dropped. func =
//   filter runs sample_in through all sections and returns one response on
//   rsp_bus with sample_out and the saturated flag. load every coefficient
//   word before the first sample.
//   sequence: each product is a multiply step, then a round and accumulate
//   step; there are seven products per section plus the total gain, then
//   one rounding step before rsp_bus.valid rises. req_bus.ready is high
//   only while idle, so one sample is taken at a time and the next request
//   waits until the current sample has left the rounding step.
//   the response sits in an output register; a stalled receiver does not
//   block the next request, only the final rounding step of the next
//   sample waits until the register is free.
//   reset clears the section delays and the handshake state; the
//   coefficient memory keeps its contents and is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_biquad_iir_filter_unit #(
   parameter int SECTIONS = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   cbiq_req_if.sink       req_bus,
   cbiq_rsp_if.source     rsp_bus
);
   import cbiq_pkg::*;

   localparam int DEPTH = SECTIONS * WORDS_PER_SECTION + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
   localparam int RND_W = VALUE_W - 7;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MUL   = 4'b0010,
      ST_ACC   = 4'b0100,
      ST_ROUND = 4'b1000
   } state_type;

   // sequencer
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [AW-1:0]          base_ff, base_in;
   logic [SEC_W-1:0]       sec_ff, sec_in;
   logic                   last_sec;

   // datapath registers
   logic [VALUE_W-1:0]     x_ff, x_in;      // section input, later its output
   logic [VALUE_W-1:0]     w_ff, w_in;      // new delay value of the section
   logic [VALUE_W-1:0]     tmp_ff, tmp_in;  // inner term, then feed-forward sum
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                   sat_ff, sat_in;

   // coefficient memory
   logic [COEF_W-1:0]      coef_mem [DEPTH];
   logic signed [COEF_W-1:0] coef_q;
   logic [AW-1:0]          rd_addr;
   logic                   coef_we;

   // section delays
   logic [VALUE_W-1:0]     delay_one_ff [SECTIONS];
   logic [VALUE_W-1:0]     delay_two_ff [SECTIONS];
   logic                   delay_we;
   logic [VALUE_W-1:0]     w1, w2;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]    rsp_sample_ff, rsp_sample_in;
   logic                   rsp_sat_ff, rsp_sat_in;

   // product and accumulate terms
   logic signed [VALUE_W-1:0] opnd_sel;
   logic [ACC_W-1:0]       acc_base, addend, sum;
   logic                   subtract, cin;
   logic [VALUE_W-1:0]     sum_sat;
   logic                   sum_ovf;
   logic [RND_W-1:0]       rnd;
   logic                   rnd_ovf;
   logic [SAMPLE_W-1:0]    rnd_sat;
   logic                   req_fire;

   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign req_fire           = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = rsp_sample_ff;
   assign rsp_bus.saturated  = rsp_sat_ff;

   assign w1       = delay_one_ff[sec_ff];
   assign w2       = delay_two_ff[sec_ff];
   assign last_sec = (sec_ff == SEC_W'(SECTIONS - 1));

   // coefficient fetch always follows the next product in the sequence
   assign rd_addr = base_in + AW'(coef_offset(op_in));
   assign coef_we = req_fire && (req_bus.func == FUNC_COEF) &&
                    (req_bus.coef_addr < ADDR_W'(DEPTH));

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[req_bus.coef_addr[AW-1:0]] <= req_bus.coef_value;
      end
      coef_q <= coef_mem[rd_addr];
   end

   // operand of the shared multiplier
   always_comb begin
      case (op_ff)
         OP_A1W1, OP_B1W1: opnd_sel = w1;
         OP_A2W2, OP_B2W2: opnd_sel = w2;
         OP_A0T, OP_GAIN:  opnd_sel = tmp_ff;
         OP_B0W:           opnd_sel = w_ff;
         default:          opnd_sel = x_ff;
      endcase
   end

   assign prod_in = coef_q * opnd_sel;

   // rounding half up folds into the adder carry: floor(p/2^28) + p[27]
   always_comb begin
      case (op_ff)
         OP_A1W1:                          acc_base = {{(ACC_W-VALUE_W){x_ff[VALUE_W-1]}}, x_ff};
         OP_A0T, OP_B0W, OP_GAIN, OP_TOTAL: acc_base = '0;
         default:                          acc_base = acc_ff;
      endcase
      subtract = op_ff inside {OP_A1W1, OP_A2W2};
      addend   = {{(ACC_W-(PROD_W-FRAC_SH)){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:FRAC_SH]};
      cin      = prod_ff[FRAC_SH-1];
      if (subtract) begin
         addend = ~addend;
         cin    = ~cin;
      end
      sum     = acc_base + addend + {{(ACC_W-1){1'b0}}, cin};
      sum_sat = sat32(sum);
      sum_ovf = sat_ovf(sum);
   end

   // final Q8.23 to Q1.15: floor((v + 128) / 256), clipped
   always_comb begin
      rnd     = {x_ff[VALUE_W-1], x_ff[VALUE_W-1:8]} + {{(RND_W-1){1'b0}}, x_ff[7]};
      rnd_ovf = !((&rnd[RND_W-1:SAMPLE_W-1]) || !(|rnd[RND_W-1:SAMPLE_W-1]));
      if (rnd_ovf) begin
         rnd_sat = rnd[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         rnd_sat = rnd[SAMPLE_W-1:0];
      end
   end

   // sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      base_in       = base_ff;
      sec_in        = sec_ff;
      x_in          = x_ff;
      w_in          = w_ff;
      tmp_in        = tmp_ff;
      acc_in        = acc_ff;
      sat_in        = sat_ff;
      delay_we      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_bus.func == FUNC_FILTER)) begin
               // sample enters as Q8.23
               x_in     = {{(VALUE_W-SAMPLE_W-8){req_bus.sample_in[SAMPLE_W-1]}},
                           req_bus.sample_in, 8'd0};
               sat_in   = 1'b0;
               sec_in   = '0;
               base_in  = '0;
               op_in    = OP_A1W1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = sum;
            state_in = ST_MUL;
            case (op_ff)
               OP_A1W1: op_in = OP_A2W2;
               OP_A2W2: begin
                  tmp_in = sum_sat;
                  sat_in = sat_ff | sum_ovf;
                  op_in  = OP_A0T;
               end
               OP_A0T: begin
                  w_in   = sum_sat;
                  sat_in = sat_ff | sum_ovf;
                  op_in  = OP_B0W;
               end
               OP_B0W:  op_in = OP_B1W1;
               OP_B1W1: op_in = OP_B2W2;
               OP_B2W2: begin
                  tmp_in = sum_sat;
                  sat_in = sat_ff | sum_ovf;
                  op_in  = OP_GAIN;
               end
               OP_GAIN: begin
                  // section output feeds the next section, delays shift
                  x_in     = sum_sat;
                  sat_in   = sat_ff | sum_ovf;
                  delay_we = 1'b1;
                  base_in  = base_ff + AW'(WORDS_PER_SECTION);
                  if (last_sec) begin
                     op_in = OP_TOTAL;
                  end else begin
                     sec_in = sec_ff + SEC_W'(1);
                     op_in  = OP_A1W1;
                  end
               end
               OP_TOTAL: begin
                  x_in     = sum_sat;
                  sat_in   = sat_ff | sum_ovf;
                  state_in = ST_ROUND;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_ROUND: begin
            // wait here only while the previous response is still held
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = rnd_sat;
               rsp_sat_in    = sat_ff | rnd_ovf;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_A1W1;
         base_ff      <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         base_ff      <= base_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
         sat_ff       <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      w_ff          <= w_in;
      tmp_ff        <= tmp_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SECTIONS; i++) begin
            delay_one_ff[i] <= '0;
            delay_two_ff[i] <= '0;
         end
      end else if (delay_we) begin
         delay_two_ff[sec_ff] <= delay_one_ff[sec_ff];
         delay_one_ff[sec_ff] <= w_ff;
      end
   end

endmodule

`default_nettype wire
